@@ src/sdt_pkg.sv @@
`default_nettype none

package sdt_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES     = 8192;
  localparam int FIRST_ALLOCATABLE = 3;
  localparam int IDX_W             = $clog2(TABLE_ENTRIES);

  // Entry marks are kept as rows of lanes so the allocator scans a row per cycle
  localparam int MARK_W      = 2;
  localparam int LANES       = 64;
  localparam int LANE_W      = $clog2(LANES);
  localparam int ROWS        = TABLE_ENTRIES / LANES;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int ROW_BITS    = LANES * MARK_W;
  localparam int GROUP_LANES = 8;
  localparam int GROUPS      = LANES / GROUP_LANES;
  localparam int GRP_W       = $clog2(GROUPS);
  localparam int SUB_W       = $clog2(GROUP_LANES);

  // Field widths
  localparam int OP_W     = 3;
  localparam int INDEX_W  = 13;
  localparam int SEL_W    = 16;
  localparam int LIMIT_W  = 32;
  localparam int BASE_W   = 32;
  localparam int ACCESS_W = 16;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 14;
  localparam int DESC_W   = 64;
  localparam int SLIM_W   = 20;

  typedef enum logic [OP_W-1:0] {
    OP_SET     = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_FREE    = 3'd2,
    OP_RD_BASE = 3'd3,
    OP_RD_SIZE = 3'd4,
    OP_COUNT   = 3'd5
  } op_e;

  typedef enum logic [MARK_W-1:0] {
    MARK_FREE  = 2'd0,
    MARK_BUSY  = 2'd1,
    MARK_ALLOC = 2'd2
  } mark_e;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [DESC_W-1:0] data;
  } desc_wr_t;

  typedef struct packed {
    logic                en;
    logic [ROW_W-1:0]    addr;
    logic [ROW_BITS-1:0] data;
  } mark_wr_t;

  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
  } scan_res_t;

endpackage

`default_nettype wire

@@ src/sdt_desc_ram.sv @@
`default_nettype none

module sdt_desc_ram (
  input  logic                       clk,
  input  sdt_pkg::desc_wr_t          wr,
  input  logic [sdt_pkg::IDX_W-1:0]  raddr,
  output logic [sdt_pkg::DESC_W-1:0] rdata
);
  import sdt_pkg::*;

  logic [DESC_W-1:0] mem [TABLE_ENTRIES];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/sdt_mark_ram.sv @@
`default_nettype none

module sdt_mark_ram (
  input  logic                         clk,
  input  sdt_pkg::mark_wr_t            wr,
  input  logic [sdt_pkg::ROW_W-1:0]    raddr,
  output logic [sdt_pkg::ROW_BITS-1:0] rdata
);
  import sdt_pkg::*;

  logic [ROW_BITS-1:0] mem [ROWS];

  // Row-wide marks, updated by read-modify-write in the sequencer
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/sdt_row_scan.sv @@
`default_nettype none

module sdt_row_scan (
  input  logic [sdt_pkg::ROW_BITS-1:0] row,
  input  logic                         first_row,
  output sdt_pkg::scan_res_t           res
);
  import sdt_pkg::*;

  localparam int FA_LANE = FIRST_ALLOCATABLE % LANES;

  logic [LANES-1:0]       free_vec;
  logic [GROUPS-1:0]      grp_any;
  logic [GRP_W-1:0]       gsel;
  logic [GROUP_LANES-1:0] sub;
  logic [SUB_W-1:0]       ssel;

  // Free lanes; lanes below the first allocatable entry are masked on its row
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      free_vec[j] = (mark_e'(row[j*MARK_W +: MARK_W]) == MARK_FREE) &&
                    !(first_row && (j < FA_LANE));
    end
  end

  // Two-level priority pick: lowest group with a free lane, then lowest lane in it
  always_comb begin
    gsel = '0;
    ssel = '0;
    for (int g = 0; g < GROUPS; g++) begin
      grp_any[g] = |free_vec[g*GROUP_LANES +: GROUP_LANES];
    end
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        gsel = GRP_W'(g);
      end
    end
    sub = free_vec[gsel*GROUP_LANES +: GROUP_LANES];
    for (int k = GROUP_LANES - 1; k >= 0; k--) begin
      if (sub[k]) begin
        ssel = SUB_W'(k);
      end
    end
    res.hit  = |grp_any;
    res.lane = {gsel, ssel};
  end

endmodule

`default_nettype wire

@@ src/segment_descriptor_table_top.sv @@
`default_nettype none

// Channel  Handshake               Payload
// in       in_valid / in_ready     op, index, selector, seg_limit, seg_base, access
// out      out_valid / out_ready   value
//
// After reset a clearing pass zeroes the descriptor and mark memories; in_ready
// stays low through it.
// Set, free, reads and count: the request is registered on acceptance, executed
// in S_EXEC and loaded into the output register in S_RESP.
// Allocate: one 64-entry mark row per cycle through the row scanner in S_SCAN,
// up to the 128 rows of the mark memory, then the result is loaded in S_RESP.
// A new transaction is taken while the previous result still waits on out_ready;
// a finished result then holds until the output register frees up.

module segment_descriptor_table_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sdt_pkg::OP_W-1:0]     op,
  input  logic [sdt_pkg::INDEX_W-1:0]  index,
  input  logic [sdt_pkg::SEL_W-1:0]    selector,
  input  logic [sdt_pkg::LIMIT_W-1:0]  seg_limit,
  input  logic [sdt_pkg::BASE_W-1:0]   seg_base,
  input  logic [sdt_pkg::ACCESS_W-1:0] access,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sdt_pkg::VALUE_W-1:0]  value
);
  import sdt_pkg::*;

  localparam logic [ROW_W-1:0] ALLOC_ROW0 = ROW_W'(FIRST_ALLOCATABLE / LANES);
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [IDX_W-1:0] CLR_LAST   = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RESP
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     clr_cnt;
  logic [COUNT_W-1:0]   used_count;
  logic [COUNT_W-1:0]   count_next;
  logic [ROW_W-1:0]     scan_row;
  op_e                  op_q;
  logic [INDEX_W-1:0]   tgt_q;
  logic                 in_tbl_q;
  logic [LIMIT_W-1:0]   lim_q;
  logic [BASE_W-1:0]    base_q;
  logic [ACCESS_W-1:0]  acc_q;
  logic [VALUE_W-1:0]   res;
  logic [VALUE_W-1:0]   exec_val;

  logic [INDEX_W-1:0]   tgt_in;
  logic [LANE_W-1:0]    lane_q;
  mark_e                old_mark;
  mark_e                new_mark;
  logic [SLIM_W-1:0]    rd_lim;
  logic [ROW_BITS-1:0]  mark_rd;
  logic [ROW_BITS-1:0]  row_mod;
  logic [ROW_W-1:0]     mark_raddr;
  logic [DESC_W-1:0]    desc_rd;
  desc_wr_t             desc_wr;
  mark_wr_t             mark_wr;
  scan_res_t            scan;

  // Descriptor packing: large limits switch to 4 KiB granularity
  function automatic logic [DESC_W-1:0] pack_desc(
    input logic [LIMIT_W-1:0]  lim,
    input logic [BASE_W-1:0]   bas,
    input logic [ACCESS_W-1:0] acc
  );
    logic              gran;
    logic [SLIM_W-1:0] slim;
    gran = (lim > LIMIT_W'(20'hFFFFF));
    slim = gran ? lim[LIMIT_W-1:12] : lim[SLIM_W-1:0];
    return {bas[31:24], acc[15] | gran, acc[14:12], slim[19:16],
            acc[7:0], bas[23:0], slim[15:0]};
  endfunction

  assign in_ready = (state == S_IDLE);

  // Free addresses its entry by selector / 8
  assign tgt_in = (op_e'(op) == OP_FREE) ? selector[SEL_W-1:3] : index;

  // Memory read addresses
  always_comb begin
    case (state)
      S_IDLE:  mark_raddr = (op_e'(op) == OP_ALLOC) ? ALLOC_ROW0 : tgt_in[IDX_W-1:LANE_W];
      S_SCAN:  mark_raddr = scan_row + ROW_W'(1);
      default: mark_raddr = '0;
    endcase
  end

  sdt_desc_ram u_desc_ram (
    .clk   (clk),
    .wr    (desc_wr),
    .raddr (tgt_in[IDX_W-1:0]),
    .rdata (desc_rd)
  );

  sdt_mark_ram u_mark_ram (
    .clk   (clk),
    .wr    (mark_wr),
    .raddr (mark_raddr),
    .rdata (mark_rd)
  );

  sdt_row_scan u_row_scan (
    .row       (mark_rd),
    .first_row (scan_row == ALLOC_ROW0),
    .res       (scan)
  );

  // Mark update and result for the single-access operations
  always_comb begin
    lane_q   = tgt_q[LANE_W-1:0];
    old_mark = mark_e'(mark_rd[{lane_q, 1'b0} +: MARK_W]);
    new_mark = (op_q == OP_FREE) ? MARK_FREE : MARK_BUSY;
    rd_lim   = {desc_rd[51:48], desc_rd[15:0]};

    count_next = used_count;
    if (in_tbl_q && (op_q == OP_SET || op_q == OP_FREE)) begin
      if (old_mark == MARK_FREE && new_mark != MARK_FREE) begin
        count_next = used_count + COUNT_W'(1);
      end else if (old_mark != MARK_FREE && new_mark == MARK_FREE) begin
        count_next = used_count - COUNT_W'(1);
      end
    end

    exec_val = '0;
    case (op_q)
      OP_RD_BASE: begin
        if (in_tbl_q && old_mark != MARK_FREE) begin
          exec_val = {desc_rd[63:56], desc_rd[39:16]};
        end
      end
      OP_RD_SIZE: begin
        if (in_tbl_q && old_mark != MARK_FREE) begin
          exec_val = desc_rd[55] ? {rd_lim, 12'h000} : VALUE_W'(rd_lim);
        end
      end
      OP_COUNT: exec_val = VALUE_W'(used_count);
      default:  exec_val = '0;
    endcase
  end

  // Memory writes: clearing pass, set/free row update, allocation claim
  always_comb begin
    desc_wr = '0;
    mark_wr = '0;
    row_mod = mark_rd;
    case (state)
      S_CLEAR: begin
        desc_wr = '{en: 1'b1, addr: clr_cnt, data: '0};
        mark_wr = '{en: 1'b1, addr: clr_cnt[ROW_W-1:0], data: '0};
      end
      S_EXEC: begin
        row_mod[{lane_q, 1'b0} +: MARK_W] = new_mark;
        if (in_tbl_q && (op_q == OP_SET || op_q == OP_FREE)) begin
          mark_wr = '{en: 1'b1, addr: tgt_q[IDX_W-1:LANE_W], data: row_mod};
        end
        if (in_tbl_q && op_q == OP_SET) begin
          desc_wr = '{en: 1'b1, addr: tgt_q[IDX_W-1:0],
                      data: pack_desc(lim_q, base_q, acc_q)};
        end
      end
      S_SCAN: begin
        row_mod[{scan.lane, 1'b0} +: MARK_W] = MARK_ALLOC;
        if (scan.hit) begin
          mark_wr = '{en: 1'b1, addr: scan_row, data: row_mod};
        end
      end
      default: begin
        desc_wr = '0;
        mark_wr = '0;
      end
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // The response step reloads the output register itself
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + IDX_W'(1);
          if (clr_cnt == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q     <= op_e'(op);
            tgt_q    <= tgt_in;
            in_tbl_q <= ({1'b0, tgt_in} < (INDEX_W + 1)'(TABLE_ENTRIES));
            lim_q    <= seg_limit;
            base_q   <= seg_base;
            acc_q    <= access;
            scan_row <= ALLOC_ROW0;
            state    <= (op_e'(op) == OP_ALLOC) ? S_SCAN : S_EXEC;
          end
        end
        S_EXEC: begin
          used_count <= count_next;
          res        <= exec_val;
          state      <= S_RESP;
        end
        S_SCAN: begin
          if (scan.hit) begin
            used_count <= used_count + COUNT_W'(1);
            res        <= VALUE_W'({scan_row, scan.lane, 3'b000});
            state      <= S_RESP;
          end else if (scan_row == ROW_LAST) begin
            res   <= '0;
            state <= S_RESP;
          end else begin
            scan_row <= scan_row + ROW_W'(1);
          end
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            value     <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, used_count} <= (COUNT_W + 1)'(TABLE_ENTRIES)))
    else $error("used count above table size");

  a_scan_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan.hit) |-> ({scan_row, scan.lane} >= IDX_W'(FIRST_ALLOCATABLE)))
    else $error("allocation below first allocatable entry");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready while a transaction is in work");

  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    (state != S_EXEC && state != S_SCAN) |=> $stable(used_count))
    else $error("used count moved outside an update step");

endmodule

`default_nettype wire

@@ bench/sdt_checker.sv @@
`timescale 1ns / 1ps

module sdt_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [sdt_pkg::OP_W-1:0]     op,
  input  logic [sdt_pkg::INDEX_W-1:0]  index,
  input  logic [sdt_pkg::SEL_W-1:0]    selector,
  input  logic [sdt_pkg::LIMIT_W-1:0]  seg_limit,
  input  logic [sdt_pkg::BASE_W-1:0]   seg_base,
  input  logic [sdt_pkg::ACCESS_W-1:0] access,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [sdt_pkg::VALUE_W-1:0]  value,
  output int                           errors,
  output int                           pending
);
  import sdt_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [OP_W-1:0]    req_op;
    logic [INDEX_W-1:0] req_index;
    logic [VALUE_W-1:0] value;
  } expected_t;

  // Shadow copy of the table, its marks and the used-entry counter
  logic [DESC_W-1:0]  desc_copy [TABLE_ENTRIES];
  mark_e              mark_copy [TABLE_ENTRIES];
  logic [COUNT_W-1:0] used_entries;
  expected_t          expected_values [$];
  expected_t          incoming;
  expected_t          oldest;

  // x86 descriptor layout; large limits switch to 4 KiB granularity
  function automatic logic [DESC_W-1:0] pack_descriptor(
    input logic [LIMIT_W-1:0]  lim,
    input logic [BASE_W-1:0]   base_addr,
    input logic [ACCESS_W-1:0] acc
  );
    logic [LIMIT_W-1:0]  l;
    logic [ACCESS_W-1:0] a;
    l = lim;
    a = acc;
    if (l > 32'h000F_FFFF) begin
      a[15] = 1'b1;
      l     = l >> 12;
    end
    return {base_addr[31:24], a[15:12], l[19:16], a[7:0], base_addr[23:0], l[15:0]};
  endfunction

  // Mark change, keeping the count of entries that are not free
  function automatic void remark(input int i, input mark_e m);
    if (mark_copy[i] == MARK_FREE && m != MARK_FREE)
      used_entries = used_entries + 1'b1;
    else if (mark_copy[i] != MARK_FREE && m == MARK_FREE)
      used_entries = used_entries - 1'b1;
    mark_copy[i] = m;
  endfunction

  // Applies one request to the shadow table and returns the value it yields
  function automatic logic [VALUE_W-1:0] serve_request(
    input logic [OP_W-1:0]     o,
    input logic [INDEX_W-1:0]  idx,
    input logic [SEL_W-1:0]    sel,
    input logic [LIMIT_W-1:0]  lim,
    input logic [BASE_W-1:0]   base_addr,
    input logic [ACCESS_W-1:0] acc
  );
    logic [VALUE_W-1:0] result;
    logic [DESC_W-1:0]  d;
    bit                 found;
    result = '0;
    found  = 1'b0;
    d      = desc_copy[idx];
    case (o)
      OP_SET: begin
        desc_copy[idx] = pack_descriptor(lim, base_addr, acc);
        remark(idx, MARK_BUSY);
      end
      OP_ALLOC: begin
        for (int i = FIRST_ALLOCATABLE; i < TABLE_ENTRIES && !found; i++) begin
          if (mark_copy[i] == MARK_FREE) begin
            remark(i, MARK_ALLOC);
            result = VALUE_W'(i * 8);
            found  = 1'b1;
          end
        end
      end
      OP_FREE: remark(sel >> 3, MARK_FREE);
      OP_RD_BASE: begin
        if (mark_copy[idx] != MARK_FREE) result = {d[63:56], d[39:16]};
      end
      OP_RD_SIZE: begin
        if (mark_copy[idx] != MARK_FREE) begin
          result = {12'd0, d[51:48], d[15:0]};
          if (d[55]) result = result << 12;
        end
      end
      OP_COUNT: result = VALUE_W'(used_entries);
      default: ;
    endcase
    return result;
  endfunction

  task automatic report_mismatch(
    input string              what,
    input logic [OP_W-1:0]    o,
    input logic [INDEX_W-1:0] idx,
    input logic [VALUE_W-1:0] want,
    input logic [VALUE_W-1:0] got
  );
    errors = errors + 1;
    if (errors <= MAX_PRINTED)
      $display("%0t: %s (op %0d index %0d) expected %h got %h",
               $time, what, o, idx, want, got);
  endtask

  // Both channels are sampled at the rising edge; results retire before new requests
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        desc_copy[i] = '0;
        mark_copy[i] = MARK_FREE;
      end
      used_entries = '0;
      expected_values.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          report_mismatch("result with no transaction outstanding", '0, '0, '0, value);
        end else begin
          oldest = expected_values.pop_front();
          if (value !== oldest.value)
            report_mismatch("wrong value", oldest.req_op, oldest.req_index,
                            oldest.value, value);
        end
      end
      if (in_valid && in_ready) begin
        incoming.req_op    = op;
        incoming.req_index = index;
        incoming.value     = serve_request(op, index, selector, seg_limit, seg_base, access);
        expected_values.push_back(incoming);
      end
    end
    pending = expected_values.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import sdt_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

  localparam int RANDOM_ITEMS = 1864;
  localparam int WINDOW_TOP   = 383;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 200;
  // No transaction is accepted during the clearing pass after reset
  localparam int IDLE_LIMIT   = 40000;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     op        = '0;
  logic [INDEX_W-1:0]  index     = '0;
  logic [SEL_W-1:0]    selector  = '0;
  logic [LIMIT_W-1:0]  seg_limit = '0;
  logic [BASE_W-1:0]   seg_base  = '0;
  logic [ACCESS_W-1:0] access    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [VALUE_W-1:0]  value;

  int   errors;
  int   pending;
  int   sent_by_op [8];
  int   idle_cycles;
  logic hold_req = 1'b0;
  bit   hold_done;
  int   rx_mode;
  int   rx_span;

  always #5 clk = ~clk;

  segment_descriptor_table_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .index     (index),
    .selector  (selector),
    .seg_limit (seg_limit),
    .seg_base  (seg_base),
    .access    (access),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value)
  );

  sdt_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .index     (index),
    .selector  (selector),
    .seg_limit (seg_limit),
    .seg_base  (seg_base),
    .access    (access),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .errors    (errors),
    .pending   (pending)
  );

  // Limits around the granularity threshold plus random ones
  function automatic logic [LIMIT_W-1:0] random_limit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'h000F_FFFF;
      2: return 32'h0010_0000;
      3: return '1;
      4, 5: return $urandom_range(0, 32'h000F_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send(
    input logic [OP_W-1:0]     o,
    input logic [INDEX_W-1:0]  idx,
    input logic [SEL_W-1:0]    sel,
    input logic [LIMIT_W-1:0]  lim,
    input logic [BASE_W-1:0]   base_addr,
    input logic [ACCESS_W-1:0] acc
  );
    op        <= o;
    index     <= idx;
    selector  <= sel;
    seg_limit <= lim;
    seg_base  <= base_addr;
    access    <= acc;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_by_op[o] = sent_by_op[o] + 1;
    @(negedge clk);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic send_random();
    logic [OP_W-1:0]    o;
    logic [INDEX_W-1:0] idx;
    logic [SEL_W-1:0]   sel;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)      o = OP_SET;
    else if (pick < 45) o = OP_ALLOC;
    else if (pick < 60) o = OP_FREE;
    else if (pick < 74) o = OP_RD_BASE;
    else if (pick < 88) o = OP_RD_SIZE;
    else if (pick < 96) o = OP_COUNT;
    else                o = $urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B;
    // Most traffic stays in a low window so reads and frees meet live entries
    if ($urandom_range(0, 4) != 0) idx = INDEX_W'($urandom_range(0, WINDOW_TOP));
    else                           idx = INDEX_W'($urandom_range(0, TABLE_ENTRIES - 1));
    if ($urandom_range(0, 9) < 7)
      sel = SEL_W'($urandom_range(0, WINDOW_TOP) * 8 + $urandom_range(0, 7));
    else
      sel = SEL_W'($urandom_range(0, 16'hFFFF));
    send(o, idx, sel, random_limit(), $urandom, ACCESS_W'($urandom_range(0, 16'hFFFF)));
  endtask

  // Output side: stall patterns in segments, one long hold-off on request
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        rx_mode = $urandom_range(0, 3);
        rx_span = $urandom_range(4, 48);
        repeat (rx_span) begin
          case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ~out_ready;
          endcase
          @(negedge clk);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: %0d cycles without a transaction, %0d outstanding",
               idle_cycles, pending);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent;
    int burst;
    int total;
    bit drained_once;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Empty table, extreme fields, granularity edges
    send(OP_COUNT,   '0,   '0, '0, '0, '0);
    send(OP_RD_BASE, 100,  '0, '0, '0, '0);
    send(OP_RD_SIZE, 100,  '0, '0, '0, '0);
    send(OP_SET,     0,    '0, '0, '0, '0);
    send(OP_SET,     8191, '1, '1, '1, '1);
    send(OP_SET,     5,    '0, 32'h000F_FFFF, 32'h1234_5678, 16'h0F9A);
    send(OP_SET,     6,    '0, 32'h0010_0000, 32'hA5A5_0000, 16'h0092);
    send(OP_SET,     7,    '0, 32'h0000_0FFF, 32'h0000_1000, 16'h8092);
    send(OP_RD_BASE, 8191, '0, '0, '0, '0);
    send(OP_RD_SIZE, 8191, '0, '0, '0, '0);
    send(OP_RD_SIZE, 5,    '0, '0, '0, '0);
    send(OP_RD_SIZE, 6,    '0, '0, '0, '0);
    send(OP_RD_SIZE, 7,    '0, '0, '0, '0);
    send(OP_RD_BASE, 5,    '0, '0, '0, '0);
    // Allocation skips reserved and busy entries
    send(OP_ALLOC,   '0,   '0, '0, '0, '0);
    send(OP_ALLOC,   '0,   '0, '0, '0, '0);
    send(OP_ALLOC,   '0,   '0, '0, '0, '0);
    // Set over an allocated entry, free twice, reuse of a freed entry
    send(OP_SET,     3,    '0, 32'h0000_FFFF, 32'h0040_0000, 16'h00F2);
    send(OP_FREE,    '0,   16'd37, '0, '0, '0);
    send(OP_FREE,    '0,   16'd37, '0, '0, '0);
    send(OP_COUNT,   '0,   '0, '0, '0, '0);
    send(OP_ALLOC,   '0,   '0, '0, '0, '0);
    send(OP_RSVD_A,  '1,   '1, '1, '1, '1);
    send(OP_RSVD_B,  '0,   '0, '0, '0, '0);
    send(OP_FREE,    '0,   16'hFFFF, '0, '0, '0);
    send(OP_RD_BASE, 8191, '0, '0, '0, '0);

    // Random traffic in bursts; one long output stall and one full drain
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < RANDOM_ITEMS) begin
        send_random();
        sent++;
        burst--;
      end
      if (sent >= 300 && !hold_req) hold_req <= 1'b1;
      if (sent >= 1000 && !drained_once) begin
        drained_once = 1'b1;
        wait_results();
      end else if ($urandom_range(0, 3) != 0) begin
        pause($urandom_range(1, 12));
      end
    end

    // Closing checks on the table left by the random traffic
    wait_results();
    send(OP_ALLOC,   '0,   '0, '0, '0, '0);
    send(OP_COUNT,   '0,   '0, '0, '0, '0);
    send(OP_FREE,    '0,   16'hFFFF, '0, '0, '0);
    send(OP_FREE,    '0,   16'd24, '0, '0, '0);
    send(OP_ALLOC,   '0,   '0, '0, '0, '0);
    send(OP_ALLOC,   '0,   '0, '0, '0, '0);
    send(OP_ALLOC,   '0,   '0, '0, '0, '0);
    send(OP_RD_SIZE, 8191, '0, '0, '0, '0);
    send(OP_RD_BASE, 3,    '0, '0, '0, '0);
    send(OP_COUNT,   '0,   '0, '0, '0, '0);

    wait_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    total = 0;
    foreach (sent_by_op[k]) total += sent_by_op[k];
    $display("Covered %0d transactions: %0d set, %0d allocate, %0d free,",
             total, sent_by_op[OP_SET], sent_by_op[OP_ALLOC], sent_by_op[OP_FREE]);
    $display("  %0d read, %0d count, %0d reserved op; %0d-cycle output stall applied",
             sent_by_op[OP_RD_BASE] + sent_by_op[OP_RD_SIZE], sent_by_op[OP_COUNT],
             sent_by_op[OP_RSVD_A] + sent_by_op[OP_RSVD_B], LONG_HOLD);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
